@@ hdl/dfcb_pkg.sv @@
// ----------------------------------------------------------------------------
// dfcb_pkg
// Shared widths, codes and types for the distance fog color blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dfcb_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int DIST_W  = 16;
   localparam int RGBA_W  = 32;
   localparam int CHAN_W  = 8;
   localparam int CHANNELS = RGBA_W / CHAN_W;

   // arithmetic widths
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 1;
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int QUO_W  = 8;
   localparam int F_W    = QUO_W + 1;

   // iterations done per pipeline stage
   localparam int SQRT_STEPS = 2;
   localparam int DIV_STEPS  = 2;

   // configuration port
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_DISTANCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_DISTANCE  = 3'd4;

   localparam logic [DIST_W-1:0] NEAR_RESET = 16'd50;
   localparam logic [DIST_W-1:0] FAR_RESET  = 16'd300;

   // blend factor selection
   localparam int FMODE_W = 2;
   localparam logic [FMODE_W-1:0] FMODE_ZERO = 2'd0;
   localparam logic [FMODE_W-1:0] FMODE_FULL = 2'd1;
   localparam logic [FMODE_W-1:0] FMODE_FRAC = 2'd2;

   localparam logic [F_W-1:0] F_ONE = 9'd256;

   // color pair riding along the pipeline
   typedef struct packed {
      logic [RGBA_W-1:0] far_rgba;
      logic [RGBA_W-1:0] near_rgba;
   } color_pair_type;

endpackage

`default_nettype wire

@@ hdl/dfcb_isqrt.sv @@
// ----------------------------------------------------------------------------
// dfcb_isqrt
// Pipelined digit-by-digit integer square root, two root bits per stage,
// with the color pair carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module dfcb_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [dfcb_pkg::SUM_W-1:0]    in_radicand,
   input  dfcb_pkg::color_pair_type           in_colors,
   output logic                               out_valid,
   output logic [dfcb_pkg::ROOT_W-1:0]        out_root,
   output dfcb_pkg::color_pair_type           out_colors
);
   import dfcb_pkg::*;

   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int STAGES = ROOT_W / SQRT_STEPS;

   logic                 valid_ff  [STAGES];
   logic [RAD_W-1:0]     rad_ff    [STAGES];
   logic [REM_W-1:0]     rem_ff    [STAGES];
   logic [ROOT_W-1:0]    root_ff   [STAGES];
   color_pair_type       colors_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic              vin;
      logic [RAD_W-1:0]  rad_in;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      color_pair_type    cin;
      logic [RAD_W-1:0]  rad_nx;
      logic [REM_W-1:0]  rem_nx;
      logic [ROOT_W-1:0] root_nx;

      // stage source
      if (s == 0) begin : g_first
         assign vin     = in_valid;
         assign rad_in  = {{(RAD_W-SUM_W){1'b0}}, in_radicand};
         assign rem_in  = '0;
         assign root_in = '0;
         assign cin     = in_colors;
      end else begin : g_next
         assign vin     = valid_ff[s-1];
         assign rad_in  = rad_ff[s-1];
         assign rem_in  = rem_ff[s-1];
         assign root_in = root_ff[s-1];
         assign cin     = colors_ff[s-1];
      end

      // trial subtract per root bit
      always_comb begin
         logic [REM_W+1:0] rem_sh;
         logic [REM_W+1:0] trial;
         rad_nx  = rad_in;
         rem_nx  = rem_in;
         root_nx = root_in;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            rem_sh = {rem_nx, rad_nx[RAD_W-1 -: 2]};
            trial  = {{(REM_W-ROOT_W){1'b0}}, root_nx, 2'b01};
            rad_nx = {rad_nx[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_nx  = REM_W'(rem_sh - trial);
               root_nx = {root_nx[ROOT_W-2:0], 1'b1};
            end else begin
               rem_nx  = rem_sh[REM_W-1:0];
               root_nx = {root_nx[ROOT_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]    <= rad_nx;
            rem_ff[s]    <= rem_nx;
            root_ff[s]   <= root_nx;
            colors_ff[s] <= cin;
         end
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_root   = root_ff[STAGES-1];
   assign out_colors = colors_ff[STAGES-1];

endmodule

`default_nettype wire

@@ hdl/dfcb_frac.sv @@
// ----------------------------------------------------------------------------
// dfcb_frac
// Pipelined restoring divider for the Q0.8 blend fraction, two quotient
// bits per stage, with the factor mode and color pair carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module dfcb_frac (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [dfcb_pkg::FMODE_W-1:0]  in_mode,
   input  wire logic [dfcb_pkg::DIST_W-1:0]   in_num,
   input  wire logic [dfcb_pkg::DIST_W-1:0]   in_den,
   input  dfcb_pkg::color_pair_type           in_colors,
   output logic                               out_valid,
   output logic [dfcb_pkg::FMODE_W-1:0]       out_mode,
   output logic [dfcb_pkg::QUO_W-1:0]         out_quo,
   output dfcb_pkg::color_pair_type           out_colors
);
   import dfcb_pkg::*;

   localparam int STAGES = QUO_W / DIV_STEPS;

   logic                 valid_ff  [STAGES];
   logic [FMODE_W-1:0]   mode_ff   [STAGES];
   logic [DIST_W-1:0]    rem_ff    [STAGES];
   logic [DIST_W-1:0]    den_ff    [STAGES];
   logic [QUO_W-1:0]     quo_ff    [STAGES];
   color_pair_type       colors_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic               vin;
      logic [FMODE_W-1:0] mode_in;
      logic [DIST_W-1:0]  rem_in;
      logic [DIST_W-1:0]  den_in;
      logic [QUO_W-1:0]   quo_in;
      color_pair_type     cin;
      logic [DIST_W-1:0]  rem_nx;
      logic [QUO_W-1:0]   quo_nx;

      // stage source
      if (s == 0) begin : g_first
         assign vin     = in_valid;
         assign mode_in = in_mode;
         assign rem_in  = in_num;
         assign den_in  = in_den;
         assign quo_in  = '0;
         assign cin     = in_colors;
      end else begin : g_next
         assign vin     = valid_ff[s-1];
         assign mode_in = mode_ff[s-1];
         assign rem_in  = rem_ff[s-1];
         assign den_in  = den_ff[s-1];
         assign quo_in  = quo_ff[s-1];
         assign cin     = colors_ff[s-1];
      end

      // shift, compare, subtract per quotient bit
      always_comb begin
         logic [DIST_W:0] rem_sh;
         rem_nx = rem_in;
         quo_nx = quo_in;
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_sh = {rem_nx, 1'b0};
            if (rem_sh >= {1'b0, den_in}) begin
               rem_nx = DIST_W'(rem_sh - {1'b0, den_in});
               quo_nx = {quo_nx[QUO_W-2:0], 1'b1};
            end else begin
               rem_nx = rem_sh[DIST_W-1:0];
               quo_nx = {quo_nx[QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= vin;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mode_ff[s]   <= mode_in;
            rem_ff[s]    <= rem_nx;
            den_ff[s]    <= den_in;
            quo_ff[s]    <= quo_nx;
            colors_ff[s] <= cin;
         end
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_mode   = mode_ff[STAGES-1];
   assign out_quo    = quo_ff[STAGES-1];
   assign out_colors = colors_ff[STAGES-1];

endmodule

`default_nettype wire

@@ hdl/distance_fog_color_blend.sv @@
// ----------------------------------------------------------------------------
// distance_fog_color_blend
// Blends a near and a far RGBA color by the camera-to-entity distance.
// Throughput: one transaction per cycle while the output skid is empty;
// depth is set by the 9-stage square root and the 4-stage fraction divider.
// A 1-entry skid follows the output.
// Reset: clears all valid bits and the skid, camera to 0, near 50, far 300.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_fog_color_blend (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration
   input  wire logic                            csr_write,
   input  wire logic [dfcb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dfcb_pkg::CSR_W-1:0]      csr_data,
   // request
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [dfcb_pkg::COORD_W-1:0] req_entity_x,
   input  wire logic signed [dfcb_pkg::COORD_W-1:0] req_entity_y,
   input  wire logic signed [dfcb_pkg::COORD_W-1:0] req_entity_z,
   input  wire logic [dfcb_pkg::RGBA_W-1:0]     req_far_rgba,
   input  wire logic [dfcb_pkg::RGBA_W-1:0]     req_near_rgba,
   // response
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [dfcb_pkg::RGBA_W-1:0]          rsp_blended_rgba
);
   import dfcb_pkg::*;

   localparam int PROD_W = F_W + CHAN_W + 1;

   // configuration registers
   logic signed [COORD_W-1:0] camera_x_ff, camera_y_ff, camera_z_ff;
   logic [DIST_W-1:0]         near_ff, far_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff <= '0;
         camera_y_ff <= '0;
         camera_z_ff <= '0;
         near_ff     <= NEAR_RESET;
         far_ff      <= FAR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CAMERA_X:      camera_x_ff <= csr_data;
            CSR_CAMERA_Y:      camera_y_ff <= csr_data;
            CSR_CAMERA_Z:      camera_z_ff <= csr_data;
            CSR_NEAR_DISTANCE: near_ff     <= csr_data;
            CSR_FAR_DISTANCE:  far_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance: frozen only while the skid holds a transaction
   logic en;
   logic skid_valid_ff;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1: coordinate differences
   logic                      v1_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, dz_ff;
   color_pair_type            col1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= {camera_x_ff[COORD_W-1], camera_x_ff} - {req_entity_x[COORD_W-1], req_entity_x};
         dy_ff <= {camera_y_ff[COORD_W-1], camera_y_ff} - {req_entity_y[COORD_W-1], req_entity_y};
         dz_ff <= {camera_z_ff[COORD_W-1], camera_z_ff} - {req_entity_z[COORD_W-1], req_entity_z};
         col1_ff.far_rgba  <= req_far_rgba;
         col1_ff.near_rgba <= req_near_rgba;
      end
   end

   // stage 2: squares
   logic                      v2_ff;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff, sqz_ff;
   color_pair_type            col2_ff;
   logic signed [2*DIFF_W-1:0] sqx_in, sqy_in, sqz_in;

   assign sqx_in = dx_ff * dx_ff;
   assign sqy_in = dy_ff * dy_ff;
   assign sqz_in = dz_ff * dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff  <= sqx_in[SQ_W-1:0];
         sqy_ff  <= sqy_in[SQ_W-1:0];
         sqz_ff  <= sqz_in[SQ_W-1:0];
         col2_ff <= col1_ff;
      end
   end

   // stage 3: sum of squares
   logic                      v3_ff;
   logic [SUM_W-1:0]          sum_ff;
   color_pair_type            col3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff  <= {1'b0, sqx_ff} + {1'b0, sqy_ff} + {1'b0, sqz_ff};
         col3_ff <= col2_ff;
      end
   end

   // distance
   logic                  root_valid;
   logic [ROOT_W-1:0]     root;
   color_pair_type        root_colors;

   dfcb_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v3_ff),
      .in_radicand (sum_ff),
      .in_colors   (col3_ff),
      .out_valid   (root_valid),
      .out_root    (root),
      .out_colors  (root_colors)
   );

   // near / far classification and fraction operands
   logic                  cmp_valid_ff;
   logic [FMODE_W-1:0]    cmp_mode_ff, cmp_mode_in;
   logic [DIST_W-1:0]     cmp_num_ff, cmp_den_ff;
   color_pair_type        cmp_colors_ff;
   logic [ROOT_W-1:0]     near_ext, far_ext;

   assign near_ext = {{(ROOT_W-DIST_W){1'b0}}, near_ff};
   assign far_ext  = {{(ROOT_W-DIST_W){1'b0}}, far_ff};

   always_comb begin
      if (root <= near_ext) begin
         cmp_mode_in = FMODE_ZERO;
      end else if (root >= far_ext) begin
         cmp_mode_in = FMODE_FULL;
      end else begin
         cmp_mode_in = FMODE_FRAC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else if (en) begin
         cmp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmp_mode_ff   <= cmp_mode_in;
         cmp_num_ff    <= root[DIST_W-1:0] - near_ff;
         cmp_den_ff    <= far_ff - near_ff;
         cmp_colors_ff <= root_colors;
      end
   end

   // blend fraction
   logic                  frac_valid;
   logic [FMODE_W-1:0]    frac_mode;
   logic [QUO_W-1:0]      frac_quo;
   color_pair_type        frac_colors;

   dfcb_frac u_frac (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (cmp_valid_ff),
      .in_mode    (cmp_mode_ff),
      .in_num     (cmp_num_ff),
      .in_den     (cmp_den_ff),
      .in_colors  (cmp_colors_ff),
      .out_valid  (frac_valid),
      .out_mode   (frac_mode),
      .out_quo    (frac_quo),
      .out_colors (frac_colors)
   );

   // factor select and per-channel products
   logic [F_W-1:0]           factor;
   logic                     mul_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [CHANNELS];
   logic [RGBA_W-1:0]        mul_near_ff;

   always_comb begin
      case (frac_mode)
         FMODE_ZERO: factor = '0;
         FMODE_FULL: factor = F_ONE;
         default:    factor = {1'b0, frac_quo};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= frac_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_near_ff <= frac_colors.near_rgba;
      end
   end

   logic [RGBA_W-1:0] blend;

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
      logic signed [CHAN_W:0]     diff;
      logic signed [F_W:0]        factor_s;
      logic signed [F_W+CHAN_W+1:0] prod_full;
      logic signed [PROD_W-1:0]   prod_adj;
      logic signed [PROD_W-9:0]   step;
      logic [PROD_W-9:0]          chan_sum;

      assign diff = $signed({1'b0, frac_colors.far_rgba[ch*CHAN_W +: CHAN_W]})
                  - $signed({1'b0, frac_colors.near_rgba[ch*CHAN_W +: CHAN_W]});
      assign factor_s  = $signed({1'b0, factor});
      assign prod_full = factor_s * diff;

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[ch] <= prod_full[PROD_W-1:0];
         end
      end

      // divide by 256 truncating toward zero, then offset from the near color
      assign prod_adj = prod_ff[ch] + (prod_ff[ch][PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      assign step     = prod_adj[PROD_W-1:8];
      assign chan_sum = {{(PROD_W-8-CHAN_W){1'b0}}, mul_near_ff[ch*CHAN_W +: CHAN_W]} + step;
      assign blend[ch*CHAN_W +: CHAN_W] = chan_sum[CHAN_W-1:0];
   end

   // output register with one-entry skid
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RGBA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              skid_valid_in;
   logic [RGBA_W-1:0] skid_data_ff, skid_data_in;
   logic              out_take;

   assign out_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (mul_valid_ff) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = blend;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = blend;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blended_rgba = rsp_data_ff;

   // checks

   // the skid only holds a transaction behind a pending response
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds data while response register is empty");

   // skid fills only when the response was stalled
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled response");

   // fraction operands keep the quotient below one
   a_frac_range : assert property (@(posedge clock) disable iff (reset)
      (cmp_valid_ff && cmp_mode_ff == FMODE_FRAC) |-> (cmp_num_ff < cmp_den_ff))
      else $error("fraction numerator not below denominator");

endmodule

`default_nettype wire

@@ bench/tb_distance_fog_color_blend.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distance_fog_color_blend
// Drives entity positions and color pairs into the fog blend pipeline under
// several camera and near/far settings. A directed table covers the corner
// distances first, then random phases follow. Every response is checked in
// order against an integer model of the distance, factor and channel math.
// ----------------------------------------------------------------------------

module tb_distance_fog_color_blend;

   import dfcb_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 240;
   localparam int RANDOM_PHASES = 8;

   // register indexes past the last real register, which the block ignores
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(CSR_FAR_DISTANCE + 1);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;

   typedef enum logic {ROW_ITEM, ROW_CSR} fog_row_kind_type;
   typedef enum logic [1:0] {STALL_OFF, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_type;

   typedef struct packed {
      fog_row_kind_type          kind;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CSR_W-1:0]          data;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic signed [COORD_W-1:0] ez;
      logic [RGBA_W-1:0]         far_c;
      logic [RGBA_W-1:0]         near_c;
      logic                      known;
      logic [RGBA_W-1:0]         blended;
   } fog_row_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_write;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_W-1:0]          csr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_entity_x;
   logic signed [COORD_W-1:0] req_entity_y;
   logic signed [COORD_W-1:0] req_entity_z;
   logic [RGBA_W-1:0]         req_far_rgba;
   logic [RGBA_W-1:0]         req_near_rgba;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [RGBA_W-1:0]         rsp_blended_rgba;

   // model copy of the registers
   logic signed [COORD_W-1:0] cam_x;
   logic signed [COORD_W-1:0] cam_y;
   logic signed [COORD_W-1:0] cam_z;
   logic [DIST_W-1:0]         near_dist;
   logic [DIST_W-1:0]         far_dist;

   logic [RGBA_W-1:0] pending_colors [$];
   logic [RGBA_W-1:0] oldest_color;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                burst_left = 0;
   stall_mode_type    stall_mode = STALL_OFF;

   // directed vectors: typed colors where they are obvious, model otherwise
   fog_row_type fog_vectors [0:33] = '{
      // reset settings: camera at origin, near 50, far 300
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh0000, 16'sh0000, 16'sh0000,
        32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh8000, 16'sh8000, 16'sh8000,
        32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sd50, 16'sd0, 16'sd0,
        32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 32'h9ABC_DEF0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sd0, -16'sd300, 16'sd0,
        32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 32'h1234_5678},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sd0, 16'sd0, 16'sd51,
        32'hFF00_FF00, 32'h00FF_00FF, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sd175, 16'sd0, 16'sd0,
        32'hFF00_FF00, 32'h00FF_00FF, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sd0, 16'sd299, 16'sd0,
        32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sd3, 16'sd4, 16'sd12,
        32'h0000_0000, 32'h1122_3344, 1'b1, 32'h1122_3344},
      // camera in the most negative corner, widest near/far span
      '{ROW_CSR, CSR_CAMERA_X, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_CAMERA_Y, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_CAMERA_Z, 16'h8000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_NEAR_DISTANCE, 16'h0000, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_FAR_DISTANCE, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh8000, 16'sh8000, 16'sh8000,
        32'h0123_4567, 32'hAABB_CCDD, 1'b1, 32'hAABB_CCDD},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh0000, 16'sh8000, 16'sh8000,
        32'h00FF_80FF, 32'hFF00_7F00, 1'b0, 32'h0},
      // far below near: anything past near is full far color
      '{ROW_CSR, CSR_NEAR_DISTANCE, 16'd100, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_FAR_DISTANCE, 16'd10, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, -16'sd32668, 16'sh8000, 16'sh8000,
        32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 32'hF0F0_F0F0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, -16'sd32667, 16'sh8000, 16'sh8000,
        32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 32'h0F0F_0F0F},
      // near and far both zero
      '{ROW_CSR, CSR_NEAR_DISTANCE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_FAR_DISTANCE, 16'd0, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh8000, 16'sh8000, 16'sh8000,
        32'h8080_8080, 32'h7F7F_7F7F, 1'b1, 32'h7F7F_7F7F},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh8000, -16'sd32767, 16'sh8000,
        32'h8080_8080, 32'h7F7F_7F7F, 1'b1, 32'h8080_8080},
      // writes to unused indexes must leave the settings alone
      '{ROW_CSR, CSR_SPARE_LO, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_SPARE_HI, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh8000, 16'sh8000, -16'sd32767,
        32'h8080_8080, 32'h7F7F_7F7F, 1'b1, 32'h8080_8080},
      // camera back at origin, near and far at the top
      '{ROW_CSR, CSR_CAMERA_X, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_CAMERA_Y, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_CAMERA_Z, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_NEAR_DISTANCE, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, CSR_FAR_DISTANCE, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0,
        32'h0, 32'h0, 1'b0, 32'h0},
      '{ROW_ITEM, CSR_CAMERA_X, 16'h0, 16'sh8000, 16'sh8000, 16'sh8000,
        32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000}
   };

   distance_fog_color_blend i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_entity_x     (req_entity_x),
      .req_entity_y     (req_entity_y),
      .req_entity_z     (req_entity_z),
      .req_far_rgba     (req_far_rgba),
      .req_near_rgba    (req_near_rgba),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blended_rgba (rsp_blended_rgba)
   );

   // clock
   always #10 clock = ~clock;

   // fog color for one entity under the current settings
   function automatic logic [RGBA_W-1:0] fog_blend(input logic signed [COORD_W-1:0] ex,
                                                   input logic signed [COORD_W-1:0] ey,
                                                   input logic signed [COORD_W-1:0] ez,
                                                   input logic [RGBA_W-1:0] far_c,
                                                   input logic [RGBA_W-1:0] near_c);
      longint dx, dy, dz, sum_sq, root, trial;
      int factor, diff, chan;
      logic [RGBA_W-1:0] color;
      dx = longint'(cam_x) - longint'(ex);
      dy = longint'(cam_y) - longint'(ey);
      dz = longint'(cam_z) - longint'(ez);
      sum_sq = dx * dx + dy * dy + dz * dz;
      // floor square root, one result bit at a time from the top
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= sum_sq) begin
            root = trial;
         end
      end
      if (root <= longint'(near_dist)) begin
         factor = 0;
      end else if (root >= longint'(far_dist)) begin
         factor = 256;
      end else begin
         factor = int'(((root - longint'(near_dist)) * 256) /
                       (longint'(far_dist) - longint'(near_dist)));
      end
      // each channel moves from near toward far, quotient truncated toward zero
      for (int k = 0; k < CHANNELS; k++) begin
         diff = int'(far_c[CHAN_W*k +: CHAN_W]) - int'(near_c[CHAN_W*k +: CHAN_W]);
         chan = int'(near_c[CHAN_W*k +: CHAN_W]) + (factor * diff) / 256;
         color[CHAN_W*k +: CHAN_W] = chan[CHAN_W-1:0];
      end
      return color;
   endfunction

   // one register write, model follows after the edge
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_CAMERA_X:      cam_x = data;
         CSR_CAMERA_Y:      cam_y = data;
         CSR_CAMERA_Z:      cam_z = data;
         CSR_NEAR_DISTANCE: near_dist = data;
         CSR_FAR_DISTANCE:  far_dist = data;
         default: ;
      endcase
   endtask

   // hold off the sender until every outstanding color has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_colors.size() != 0);
   endtask

   // one request transaction, bursts separated by random gaps
   task automatic send_fog(input logic signed [COORD_W-1:0] ex,
                           input logic signed [COORD_W-1:0] ey,
                           input logic signed [COORD_W-1:0] ez,
                           input logic [RGBA_W-1:0] far_c,
                           input logic [RGBA_W-1:0] near_c,
                           input logic [RGBA_W-1:0] want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_entity_x  <= ex;
      req_entity_y  <= ey;
      req_entity_z  <= ez;
      req_far_rgba  <= far_c;
      req_near_rgba <= near_c;
      do @(posedge clock); while (req_stall);
      pending_colors.push_back(want);
   endtask

   // new settings for a random phase, written while the pipeline is empty
   task automatic configure_fog(input logic [CSR_W-1:0] cx, input logic [CSR_W-1:0] cy,
                                input logic [CSR_W-1:0] cz, input logic [CSR_W-1:0] nd,
                                input logic [CSR_W-1:0] fd);
      drain_results();
      if ($urandom_range(0, 1) == 1) begin
         csr_put(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), CSR_W'($urandom));
      end
      csr_put(CSR_CAMERA_X, cx);
      csr_put(CSR_CAMERA_Y, cy);
      csr_put(CSR_CAMERA_Z, cz);
      csr_put(CSR_NEAR_DISTANCE, nd);
      csr_put(CSR_FAR_DISTANCE, fd);
      csr_write <= 1'b0;
   endtask

   // random entities, mostly spread around the near/far band of the camera
   task automatic run_phase(input int count);
      int span, ox, oy, oz, pick;
      logic signed [COORD_W-1:0] ex, ey, ez;
      logic [RGBA_W-1:0] far_c, near_c;
      span = ((far_dist > near_dist) ? int'(far_dist) : int'(near_dist)) + 64;
      span = span + span / 4;
      repeat (count) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            ox = int'($urandom_range(0, 2 * span)) - span;
            oy = (int'($urandom_range(0, 2 * span)) - span) / 4;
            oz = (int'($urandom_range(0, 2 * span)) - span) / 4;
         end else if (pick == 9) begin
            // on an axis, right at a threshold or one unit off
            ox = (($urandom_range(0, 1) == 1) ? int'(near_dist) : int'(far_dist)) +
                 int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1) begin
               ox = -ox;
            end
            oy = 0;
            oz = 0;
         end else begin
            ox = $urandom_range(0, 65535);
            oy = $urandom_range(0, 65535);
            oz = $urandom_range(0, 65535);
         end
         ex = COORD_W'(int'(cam_x) + ox);
         ey = COORD_W'(int'(cam_y) + oy);
         ez = COORD_W'(int'(cam_z) + oz);
         far_c  = $urandom;
         near_c = $urandom;
         if ($urandom_range(0, 7) == 0) begin
            far_c = ~near_c;
         end
         send_fog(ex, ey, ez, far_c, near_c, fog_blend(ex, ey, ez, far_c, near_c));
      end
   endtask

   // response side: stall pattern, in-order check, run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 299) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_OFF:   rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((cycle_count % 7) < 3);
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            $display("%0t: unexpected transaction, actual blended_rgba %h",
                     $time, rsp_blended_rgba);
            mismatch_count++;
         end else begin
            oldest_color = pending_colors.pop_front();
            if (rsp_blended_rgba !== oldest_color) begin
               $display("%0t: blended_rgba mismatch, expected %h actual %h",
                        $time, oldest_color, rsp_blended_rgba);
               mismatch_count++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_distance_fog_color_blend failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      fog_row_type row;
      logic [RGBA_W-1:0] want;
      int nd, fd;
      clock         = 1'b0;
      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_index     = CSR_CAMERA_X;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_entity_x  = '0;
      req_entity_y  = '0;
      req_entity_z  = '0;
      req_far_rgba  = '0;
      req_near_rgba = '0;
      cam_x         = '0;
      cam_y         = '0;
      cam_z         = '0;
      near_dist     = NEAR_RESET;
      far_dist      = FAR_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (fog_vectors[r]) begin
         row = fog_vectors[r];
         if (row.kind == ROW_CSR) begin
            if (!csr_write) begin
               drain_results();
            end
            csr_put(row.idx, row.data);
         end else begin
            if (csr_write) begin
               csr_write <= 1'b0;
            end
            want = row.known ? row.blended
                             : fog_blend(row.ex, row.ey, row.ez, row.far_c, row.near_c);
            send_fog(row.ex, row.ey, row.ez, row.far_c, row.near_c, want);
         end
      end

      // random phases over a spread of settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         nd = $urandom_range(0, 65535);
         fd = $urandom_range(0, 65535);
         case (p)
            0: configure_fog('0, '0, '0, NEAR_RESET, FAR_RESET);
            1: begin
               nd = $urandom_range(0, 2000);
               configure_fog(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom),
                             CSR_W'(nd), CSR_W'(nd + int'($urandom_range(1, 3000))));
            end
            2: configure_fog(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF);
            3: begin
               nd = $urandom_range(1, 600);
               configure_fog(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom),
                             CSR_W'(nd), CSR_W'($urandom_range(0, nd - 1)));
            end
            4: begin
               nd = $urandom_range(0, 1000);
               configure_fog(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom),
                             CSR_W'(nd), CSR_W'(nd));
            end
            5: configure_fog(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000);
            6: begin
               nd = $urandom_range(0, 200);
               configure_fog(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom),
                             CSR_W'(nd), CSR_W'(nd + int'($urandom_range(1, 20))));
            end
            default: configure_fog(CSR_W'($urandom), CSR_W'($urandom), CSR_W'($urandom),
                                   CSR_W'(nd), CSR_W'(fd));
         endcase
         run_phase(PHASE_ITEMS);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_distance_fog_color_blend passed");
      end else begin
         $display("tb_distance_fog_color_blend failed");
      end
      $finish;
   end

endmodule
